@@ src/tgd_pkg.sv @@
// Shared types and constants for the touch gesture detector.
// Used by tgd_front, tgd_back and touch_gesture_detector_top; no dependencies.
package tgd_pkg;

    localparam int READING_BITS = 16;
    localparam int TIMER_BITS   = 12;
    localparam int CMP_BITS     = 16;
    localparam int STABLE_BITS  = 8;
    localparam logic [TIMER_BITS-1:0]  TIMER_MAX  = '1;
    localparam logic [STABLE_BITS-1:0] STABLE_MAX = '1;

    typedef enum logic [1:0] {
        CFG_THRESHOLD   = 2'd0,
        CFG_DEBOUNCE    = 2'd1,
        CFG_DOUBLE_TAP  = 2'd2,
        CFG_LONG_PRESS  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_PRESSED  = 3'd2,
        PH_RELEASED = 3'd3,
        PH_LONG     = 3'd4
    } phase_t;

    typedef struct packed {
        logic [15:0] reading;
        logic        read_ok;
    } sample_t;

    typedef struct packed {
        logic [1:0] event_code;
        logic       touched;
        logic [1:0] latest_gesture;
    } result_t;

    // Classified sample handed from front to back
    typedef struct packed {
        logic ok;
        logic touched;
    } cls_t;

    typedef struct packed {
        logic [15:0] touch_threshold;
        logic [7:0]  debounce_samples;
        logic [11:0] double_tap_samples;
        logic [11:0] long_press_samples;
    } cfg_t;

endpackage

@@ src/tgd_front.sv @@
// Front end: accepts samples, compares against the threshold and queues
// the classified request for the back end. Depends on tgd_pkg.
module tgd_front
    import tgd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    push,
    input  sample_t sample,
    output logic    full,
    output logic    cls_valid,
    output cls_t    cls,
    input  logic    cls_take
);

    cls_t       q_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;
    logic [READING_BITS-1:0] rd_lo;
    logic [READING_BITS-1:0] thr_lo;
    cls_t       cls_in;

    assign full      = (cnt_reg == 2'd2);
    assign cls_valid = (cnt_reg != 2'd0);
    assign cls       = q_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cls_take && cls_valid;

    assign rd_lo  = sample.reading[READING_BITS-1:0];
    assign thr_lo = cfg.touch_threshold[READING_BITS-1:0];

    always_comb
    begin
        cls_in.ok      = sample.read_ok;
        cls_in.touched = sample.read_ok && (rd_lo < thr_lo);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wptr_reg] <= cls_in;
        end
    end

endmodule

@@ src/tgd_back.sv @@
// Back end: gesture state machine over classified samples, with a two-entry
// result queue toward the consumer. Depends on tgd_pkg.
module tgd_back
    import tgd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    cls_valid,
    input  cls_t    cls,
    output logic    cls_take,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [STABLE_BITS-1:0]  stable_reg;
    logic [STABLE_BITS-1:0]  stable_next;
    logic [TIMER_BITS-1:0]   held_reg;
    logic [TIMER_BITS-1:0]   held_next;
    logic [TIMER_BITS-1:0]   since_reg;
    logic [TIMER_BITS-1:0]   since_next;
    logic [1:0]              mem_reg;
    logic [1:0]              mem_next;
    logic [1:0]              ev;
    logic [STABLE_BITS-1:0]  stable_inc;
    result_t                 res_in;

    result_t    q_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_pop;

    assign empty    = (cnt_reg == 2'd0);
    assign result   = q_reg[rptr_reg];
    assign do_pop   = pop && !empty;
    // Take a request when the result queue has room (or frees a slot now)
    assign cls_take = cls_valid && ((cnt_reg != 2'd2) || do_pop);

    assign stable_inc = (stable_reg == STABLE_MAX) ? STABLE_MAX : stable_reg + 1'b1;

    always_comb
    begin
        phase_next  = phase_reg;
        stable_next = stable_reg;
        held_next   = held_reg;
        since_next  = since_reg;
        mem_next    = mem_reg;
        ev          = EV_NONE;

        // Elapsed counters advance before the compare, even on a failed read
        if (phase_reg == PH_PRESSED)
        begin
            held_next = (held_reg == TIMER_MAX) ? TIMER_MAX : held_reg + 1'b1;
        end
        else if (phase_reg == PH_RELEASED)
        begin
            since_next = (since_reg == TIMER_MAX) ? TIMER_MAX : since_reg + 1'b1;
        end

        if (cls.ok)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (cls.touched)
                    begin
                        phase_next  = PH_DEBOUNCE;
                        stable_next = STABLE_BITS'(1);
                    end
                end
                PH_DEBOUNCE:
                begin
                    if (cls.touched)
                    begin
                        stable_next = stable_inc;
                        if (stable_inc >= cfg.debounce_samples)
                        begin
                            phase_next = PH_PRESSED;
                            held_next  = '0;
                        end
                    end
                    else
                    begin
                        phase_next  = PH_IDLE;
                        stable_next = '0;
                    end
                end
                PH_PRESSED:
                begin
                    if (!cls.touched)
                    begin
                        phase_next = PH_RELEASED;
                        since_next = '0;
                    end
                    else if (CMP_BITS'(held_next) >= CMP_BITS'(cfg.long_press_samples))
                    begin
                        phase_next = PH_LONG;
                        mem_next   = EV_LONG;
                        ev         = EV_LONG;
                    end
                end
                PH_RELEASED:
                begin
                    if (cls.touched)
                    begin
                        phase_next  = PH_DEBOUNCE;
                        stable_next = STABLE_BITS'(1);
                        mem_next    = EV_DOUBLE;
                        ev          = EV_DOUBLE;
                    end
                    else if (CMP_BITS'(since_next) >= CMP_BITS'(cfg.double_tap_samples))
                    begin
                        phase_next = PH_IDLE;
                        mem_next   = EV_SINGLE;
                        ev         = EV_SINGLE;
                    end
                end
                PH_LONG:
                begin
                    if (!cls.touched)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        res_in.event_code     = ev;
        res_in.touched        = cls.touched;
        res_in.latest_gesture = mem_next;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cls_take && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !cls_take)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            stable_reg <= '0;
            held_reg   <= '0;
            since_reg  <= '0;
            mem_reg    <= EV_NONE;
            wptr_reg   <= 1'b0;
            rptr_reg   <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cls_take)
            begin
                phase_reg  <= phase_next;
                stable_reg <= stable_next;
                held_reg   <= held_next;
                since_reg  <= since_next;
                mem_reg    <= mem_next;
                wptr_reg   <= ~wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cls_take)
        begin
            q_reg[wptr_reg] <= res_in;
        end
    end

endmodule

@@ src/touch_gesture_detector_top.sv @@
// Touch gesture detector: one sample in, one result out, via the front queue
// and the result queue; one sample per cycle sustained while results are popped,
// set by the back end's state update. Front and back are split by a two-entry
// queue and results wait in a two-entry queue, so each side stalls on its own.
// Reset: phase idle, counters and last gesture cleared, queues empty,
// registers at threshold 0, debounce 3, double tap 15, long press 50.
module touch_gesture_detector_top
    import tgd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  sample_t     sample,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg_reg;
    logic cls_valid;
    logic cls_take;
    cls_t cls;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.touch_threshold    <= 16'd0;
            cfg_reg.debounce_samples   <= 8'd3;
            cfg_reg.double_tap_samples <= 12'd15;
            cfg_reg.long_press_samples <= 12'd50;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_THRESHOLD:  cfg_reg.touch_threshold    <= cfg_data;
                CFG_DEBOUNCE:   cfg_reg.debounce_samples   <= cfg_data[7:0];
                CFG_DOUBLE_TAP: cfg_reg.double_tap_samples <= cfg_data[11:0];
                CFG_LONG_PRESS: cfg_reg.long_press_samples <= cfg_data[11:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    tgd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .sample    (sample),
        .full      (full),
        .cls_valid (cls_valid),
        .cls       (cls),
        .cls_take  (cls_take)
    );

    tgd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cls_valid (cls_valid),
        .cls       (cls),
        .cls_take  (cls_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
